>>> src/iltbl_pkg.sv
// Shared package for the integer list table engine.
// Holds field widths, command and status codes, and the extreme word values.
// No dependencies.
`default_nettype none

package iltbl_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int INDEX_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NO_MATCH = {DATA_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_MAX    = 3'd4,
        CMD_MIN    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_DENIED    = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

endpackage

`default_nettype wire

>>> src/iltbl_ram.sv
// Entry store of the list engine: one write port, one registered read port.
// Depends on iltbl_pkg for the word width and the default depth.
`default_nettype none

module iltbl_ram #(
    parameter int DEPTH = iltbl_pkg::DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  wire logic [iltbl_pkg::DATA_W-1:0]    wr_data,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic      [iltbl_pkg::DATA_W-1:0]    rd_data
);

    logic [iltbl_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/integer_list_table_engine_core.sv
// Top level of the integer list table engine: command decode, walk sequencer,
// result registers. Depends on iltbl_pkg and iltbl_ram.
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+------------------------------
//  request   | command, value, index                    | taken when start & !busy
//  result    | status, count, result_value              | done high for one cycle
//  config    | cfg_data                                 | written when cfg_write high
//
// Flow: append, every refused request, unknown commands and max/min/search on
// an empty list finish at once: the result shows in the cycle after the request
// and busy stays low. Walking requests stream one store read per cycle through
// the single read port: insert moves entries from the tail down to index up by
// one and then writes the new word, delete moves later entries down by one (or
// finishes at once if it removes the last entry), max/min read every entry and
// search reads up to the first match. Reset clears the count and sets
// write_enable; the store holds no reset value and needs no clearing pass. The
// receiver cannot stall: each result is shown exactly once, with done high.
`default_nettype none

module integer_list_table_engine_core #(
    parameter int DEPTH = iltbl_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic        [iltbl_pkg::CMD_W-1:0]   command,
    input  wire logic signed [iltbl_pkg::DATA_W-1:0]  value,
    input  wire logic        [iltbl_pkg::INDEX_W-1:0] index,
    // configuration
    input  wire logic                                cfg_write,
    input  wire logic                                cfg_data,
    // result channel
    output logic                                     done,
    output logic        [iltbl_pkg::STATUS_W-1:0]     status,
    output logic        [iltbl_pkg::COUNT_W-1:0]      count,
    output logic signed [iltbl_pkg::DATA_W-1:0]       result_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > iltbl_pkg::INDEX_W) ? CW : iltbl_pkg::INDEX_W;
    localparam int XW = (CW > iltbl_pkg::COUNT_W) ? CW : iltbl_pkg::COUNT_W;
    localparam int DW = iltbl_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_PUT  = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              used_reg, used_next;
    logic                       write_enable_reg;
    iltbl_pkg::cmd_t            op_reg, op_next;
    logic [DW-1:0]              val_reg, val_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              rd_addr_reg, rd_addr_next;
    logic [CW-1:0]              left_reg, left_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              pend_addr_reg, pend_addr_next;
    logic [DW-1:0]              best_reg, best_next;
    logic                       done_reg, done_next;
    iltbl_pkg::status_t         status_reg, status_next;
    logic [iltbl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [DW-1:0]              result_reg, result_next;

    // store ports
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [DW-1:0]              ram_wdata;
    logic                       ram_re;
    logic [DW-1:0]              ram_rdata;

    logic [EW-1:0]              idx_x;
    logic [EW-1:0]              used_x;
    logic [EW-1:0]              moves_x;
    logic [XW-1:0]              used_next_x;
    logic                       full;
    logic                       last;
    logic [DW-1:0]              cand_max;
    logic [DW-1:0]              cand_min;

    iltbl_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rdata)
    );

    assign idx_x    = EW'(index);
    assign used_x   = EW'(used_reg);
    assign full     = (used_reg >= CW'(DEPTH));
    assign last     = (left_reg == '0);
    assign cand_max = ($signed(ram_rdata) > $signed(best_reg)) ? ram_rdata : best_reg;
    assign cand_min = ($signed(ram_rdata) < $signed(best_reg)) ? ram_rdata : best_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        rd_addr_next   = rd_addr_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        best_next      = best_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        moves_x        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Decode the request; walking commands leave done low.
                    op_next     = iltbl_pkg::cmd_t'(command);
                    val_next    = value;
                    pos_next    = AW'(index);
                    done_next   = 1'b1;
                    status_next = iltbl_pkg::ST_OK;
                    result_next = '0;
                    case (iltbl_pkg::cmd_t'(command))
                        iltbl_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = iltbl_pkg::ST_FULL;
                            end
                            else if (!write_enable_reg)
                            begin
                                status_next = iltbl_pkg::ST_DENIED;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(used_reg);
                                ram_wdata = value;
                                used_next = used_reg + 1'b1;
                            end
                        end
                        iltbl_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = iltbl_pkg::ST_FULL;
                            end
                            else if (!write_enable_reg)
                            begin
                                status_next = iltbl_pkg::ST_DENIED;
                            end
                            else if (idx_x > used_x)
                            begin
                                status_next = iltbl_pkg::ST_BAD_INDEX;
                            end
                            else if (idx_x == used_x)
                            begin
                                // Insert at the tail: a plain append.
                                ram_we    = 1'b1;
                                ram_waddr = AW'(used_reg);
                                ram_wdata = value;
                                used_next = used_reg + 1'b1;
                            end
                            else
                            begin
                                // Move entries up, from the tail down to index.
                                moves_x      = used_x - idx_x;
                                left_next    = CW'(moves_x);
                                rd_addr_next = AW'(used_reg - 1'b1);
                                used_next    = used_reg + 1'b1;
                                done_next    = 1'b0;
                                state_next   = S_WALK;
                            end
                        end
                        iltbl_pkg::CMD_DELETE:
                        begin
                            if (!write_enable_reg)
                            begin
                                status_next = iltbl_pkg::ST_DENIED;
                            end
                            else if (idx_x >= used_x)
                            begin
                                status_next = iltbl_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                used_next = used_reg - 1'b1;
                                moves_x   = used_x - idx_x - 1'b1;
                                if (moves_x != '0)
                                begin
                                    // Move later entries down by one.
                                    left_next    = CW'(moves_x);
                                    rd_addr_next = AW'(idx_x + 1'b1);
                                    done_next    = 1'b0;
                                    state_next   = S_WALK;
                                end
                            end
                        end
                        iltbl_pkg::CMD_SEARCH,
                        iltbl_pkg::CMD_MAX,
                        iltbl_pkg::CMD_MIN:
                        begin
                            if (iltbl_pkg::cmd_t'(command) == iltbl_pkg::CMD_MAX)
                            begin
                                best_next = iltbl_pkg::WORD_MIN;
                            end
                            else
                            begin
                                best_next = iltbl_pkg::WORD_MAX;
                            end
                            if (used_reg == '0)
                            begin
                                // Empty list: report the seed value or a miss.
                                if (iltbl_pkg::cmd_t'(command) == iltbl_pkg::CMD_SEARCH)
                                begin
                                    status_next = iltbl_pkg::ST_NOT_FOUND;
                                    result_next = iltbl_pkg::NO_MATCH;
                                end
                                else
                                begin
                                    result_next = best_next;
                                end
                            end
                            else
                            begin
                                left_next    = used_reg;
                                rd_addr_next = '0;
                                done_next    = 1'b0;
                                state_next   = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = iltbl_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // Issue the next read while the previous one returns.
                if (!last)
                begin
                    ram_re         = 1'b1;
                    left_next      = left_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    if (op_reg == iltbl_pkg::CMD_INSERT)
                    begin
                        rd_addr_next = rd_addr_reg - 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    case (op_reg)
                        iltbl_pkg::CMD_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_addr_reg + 1'b1;
                            ram_wdata = ram_rdata;
                            if (last)
                            begin
                                state_next = S_PUT;
                            end
                        end
                        iltbl_pkg::CMD_DELETE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_addr_reg - 1'b1;
                            ram_wdata = ram_rdata;
                            if (last)
                            begin
                                done_next   = 1'b1;
                                status_next = iltbl_pkg::ST_OK;
                                result_next = '0;
                                state_next  = S_IDLE;
                            end
                        end
                        iltbl_pkg::CMD_SEARCH:
                        begin
                            if (ram_rdata == val_reg)
                            begin
                                // First match wins; drop the read in flight.
                                done_next   = 1'b1;
                                status_next = iltbl_pkg::ST_OK;
                                result_next = DW'(pend_addr_reg);
                                state_next  = S_IDLE;
                            end
                            else if (last)
                            begin
                                done_next   = 1'b1;
                                status_next = iltbl_pkg::ST_NOT_FOUND;
                                result_next = iltbl_pkg::NO_MATCH;
                                state_next  = S_IDLE;
                            end
                        end
                        iltbl_pkg::CMD_MAX:
                        begin
                            best_next = cand_max;
                            if (last)
                            begin
                                done_next   = 1'b1;
                                status_next = iltbl_pkg::ST_OK;
                                result_next = cand_max;
                                state_next  = S_IDLE;
                            end
                        end
                        iltbl_pkg::CMD_MIN:
                        begin
                            best_next = cand_min;
                            if (last)
                            begin
                                done_next   = 1'b1;
                                status_next = iltbl_pkg::ST_OK;
                                result_next = cand_min;
                                state_next  = S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                // Drop the new word into the gap opened by the walk.
                ram_we      = 1'b1;
                ram_waddr   = pos_reg;
                ram_wdata   = val_reg;
                done_next   = 1'b1;
                status_next = iltbl_pkg::ST_OK;
                result_next = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign used_next_x = XW'(used_next);
    assign count_next  = used_next_x[iltbl_pkg::COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            used_reg         <= '0;
            write_enable_reg <= 1'b1;
            pend_reg         <= 1'b0;
            left_reg         <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                write_enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        best_reg      <= best_next;
        status_reg    <= status_next;
        result_reg    <= result_next;
        count_reg     <= count_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign count        = count_reg;
    assign result_value = result_reg;

    // The entry count never passes the store depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // An idle engine without a request leaves the store alone.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !start) |-> !ram_we)
        else $error("store written while idle");

    // The walk always has a read to issue or a read to retire.
    a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (!last || pend_reg))
        else $error("walk stalled with nothing in flight");

    // With writes denied the count holds.
    a_denied_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!write_enable_reg && state_reg == S_IDLE) |=> $stable(used_reg))
        else $error("count changed while writes denied");

    // A finished walk always reports.
    a_walk_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE) |=> done)
        else $error("walk ended without a result");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for integer_list_table_engine_core: directed and random
// list requests, with results checked against an in-bench model of the list store.
// Depends on iltbl_pkg and the engine RTL; no files, no arguments.

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = iltbl_pkg::DEPTH_DEF;
    localparam int WATCH_LIMIT = 4000;
    // hold this long after the last result, longer than the longest walk
    localparam int TAIL_CYCLES = LIST_DEPTH + 16;

    // command codes the block does not decode
    localparam logic [iltbl_pkg::CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [iltbl_pkg::CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct {
        logic        [iltbl_pkg::STATUS_W-1:0] status;
        logic        [iltbl_pkg::COUNT_W-1:0]  count;
        logic signed [iltbl_pkg::DATA_W-1:0]   value;
    } list_reply_t;

    logic                                  clk          = 1'b0;
    logic                                  rst_n        = 1'b0;
    logic                                  start        = 1'b0;
    logic        [iltbl_pkg::CMD_W-1:0]    command      = '0;
    logic signed [iltbl_pkg::DATA_W-1:0]   value        = '0;
    logic        [iltbl_pkg::INDEX_W-1:0]  index        = '0;
    logic                                  cfg_write    = 1'b0;
    logic                                  cfg_data     = 1'b0;
    logic                                  busy;
    logic                                  done;
    logic        [iltbl_pkg::STATUS_W-1:0] status;
    logic        [iltbl_pkg::COUNT_W-1:0]  count;
    logic signed [iltbl_pkg::DATA_W-1:0]   result_value;

    // model of the list: stored words, entry count and the write permission
    logic signed [iltbl_pkg::DATA_W-1:0]   list_mem [LIST_DEPTH];
    int                         list_len    = 0;
    bit                         list_wr_en  = 1'b1;
    int                         deepest_len = 0;

    list_reply_t                reply_q [$];
    list_reply_t                want;
    int                         sent_total    = 0;
    int                         checked_total = 0;
    int                         error_total   = 0;
    int                         status_seen [8];
    int                         quiet_cycles  = 0;

    integer_list_table_engine_core #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .value       (value),
        .index       (index),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .count       (count),
        .result_value(result_value)
    );

    always #5 clk = ~clk;

    // Compute the reply of one request and advance the list model as the block would.
    function automatic list_reply_t predict_reply(
        input logic        [iltbl_pkg::CMD_W-1:0]   cmd,
        input logic signed [iltbl_pkg::DATA_W-1:0]  word,
        input logic        [iltbl_pkg::INDEX_W-1:0] pos);
        list_reply_t r;
        bit          hit;
        r.status = iltbl_pkg::ST_OK;
        r.value  = '0;
        hit      = 1'b0;
        case (cmd)
            iltbl_pkg::CMD_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = iltbl_pkg::ST_FULL;
                else if (!list_wr_en)
                    r.status = iltbl_pkg::ST_DENIED;
                else
                begin
                    list_mem[list_len] = word;
                    list_len++;
                end
            end
            iltbl_pkg::CMD_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = iltbl_pkg::ST_FULL;
                else if (!list_wr_en)
                    r.status = iltbl_pkg::ST_DENIED;
                else if (int'(pos) > list_len)
                    r.status = iltbl_pkg::ST_BAD_INDEX;
                else
                begin
                    for (int i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = word;
                    list_len++;
                end
            end
            iltbl_pkg::CMD_DELETE:
            begin
                if (!list_wr_en)
                    r.status = iltbl_pkg::ST_DENIED;
                else if (int'(pos) >= list_len)
                    r.status = iltbl_pkg::ST_BAD_INDEX;
                else
                begin
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            iltbl_pkg::CMD_SEARCH:
            begin
                r.status = iltbl_pkg::ST_NOT_FOUND;
                r.value  = iltbl_pkg::NO_MATCH;
                for (int i = 0; i < list_len; i++)
                begin
                    if (!hit && list_mem[i] == word)
                    begin
                        hit      = 1'b1;
                        r.status = iltbl_pkg::ST_OK;
                        r.value  = i;
                    end
                end
            end
            iltbl_pkg::CMD_MAX:
            begin
                r.value = iltbl_pkg::WORD_MIN;
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] > r.value)
                        r.value = list_mem[i];
            end
            iltbl_pkg::CMD_MIN:
            begin
                r.value = iltbl_pkg::WORD_MAX;
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] < r.value)
                        r.value = list_mem[i];
            end
            default:
            begin
            end
        endcase
        r.count = list_len[iltbl_pkg::COUNT_W-1:0];
        if (list_len > deepest_len)
            deepest_len = list_len;
        return r;
    endfunction

    // Drive one request and hold it until the block takes it; then queue its reply.
    // Start stays high on return, so a following request goes out back to back.
    task automatic send_request(input logic [iltbl_pkg::CMD_W-1:0]   cmd,
                                input logic [iltbl_pkg::DATA_W-1:0]  word,
                                input logic [iltbl_pkg::INDEX_W-1:0] pos);
        start   <= 1'b1;
        command <= cmd;
        value   <= word;
        index   <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply_q.push_back(predict_reply(cmd, word, pos));
        sent_total++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop start and hold until every queued reply has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_write_enable(input bit enable);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= enable;
        @(posedge clk);
        cfg_write  <= 1'b0;
        list_wr_en = enable;
        @(posedge clk);
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    // Extremes and a small pool of values show up often so searches can hit.
    function automatic logic [iltbl_pkg::DATA_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return iltbl_pkg::WORD_MIN;
            1: return iltbl_pkg::WORD_MAX;
            2: return $urandom_range(0, 1) ? '0 : '1;
            3, 4, 5: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // A growing phase favors append and insert, a shrinking one favors delete.
    function automatic logic [iltbl_pkg::CMD_W-1:0] pick_command(input bit grow);
        int unsigned r;
        int          t_app, t_ins, t_del;
        r     = $urandom_range(0, 99);
        t_app = grow ? 30 : 12;
        t_ins = t_app + (grow ? 28 : 12);
        t_del = t_ins + (grow ? 10 : 44);
        if (r < t_app)
            return iltbl_pkg::CMD_APPEND;
        if (r < t_ins)
            return iltbl_pkg::CMD_INSERT;
        if (r < t_del)
            return iltbl_pkg::CMD_DELETE;
        if (r < t_del + 14)
            return iltbl_pkg::CMD_SEARCH;
        if (r < t_del + 22)
            return iltbl_pkg::CMD_MAX;
        if (r < t_del + 30)
            return iltbl_pkg::CMD_MIN;
        return $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    endfunction

    task automatic send_random_request(input bit grow);
        logic [iltbl_pkg::CMD_W-1:0]   cmd;
        logic [iltbl_pkg::DATA_W-1:0]  word;
        logic [iltbl_pkg::INDEX_W-1:0] pos;
        cmd  = pick_command(grow);
        word = pick_word();
        pos  = iltbl_pkg::INDEX_W'($urandom_range(0, LIST_DEPTH - 1));
        // most positions are legal; the rest stay random to hit the bad index path
        case (cmd)
            iltbl_pkg::CMD_INSERT:
                if ($urandom_range(0, 4) != 0)
                    pos = iltbl_pkg::INDEX_W'($urandom_range(0,
                              (list_len < LIST_DEPTH - 1) ? list_len : LIST_DEPTH - 1));
            iltbl_pkg::CMD_DELETE:
                if (list_len > 0 && $urandom_range(0, 4) != 0)
                    pos = iltbl_pkg::INDEX_W'($urandom_range(0, list_len - 1));
            iltbl_pkg::CMD_SEARCH:
                if (list_len > 0 && $urandom_range(0, 9) < 6)
                    word = list_mem[$urandom_range(0, list_len - 1)];
            default:
            begin
            end
        endcase
        send_request(cmd, word, pos);
    endtask

    // Queries and edits on an empty list, plus the unused command codes.
    task automatic test_empty_list();
        send_request(iltbl_pkg::CMD_MAX, '0, '0);
        send_request(iltbl_pkg::CMD_MIN, '0, '0);
        send_request(iltbl_pkg::CMD_SEARCH, '0, '0);
        send_request(iltbl_pkg::CMD_DELETE, '0, '0);
        send_request(iltbl_pkg::CMD_DELETE, '1, '1);
        send_request(iltbl_pkg::CMD_INSERT, 32'd5, 6'd1);
        send_request(CMD_UNUSED_6, '0, '0);
        send_request(CMD_UNUSED_7, '1, '1);
    endtask

    // Build a short list from the extreme words and walk every command over it.
    task automatic test_edit_and_query();
        send_request(iltbl_pkg::CMD_APPEND, iltbl_pkg::WORD_MAX, '0);
        send_request(iltbl_pkg::CMD_APPEND, iltbl_pkg::WORD_MIN, '1);
        send_request(iltbl_pkg::CMD_INSERT, '0, 6'd0);
        send_request(iltbl_pkg::CMD_INSERT, '1, 6'd3);
        send_request(iltbl_pkg::CMD_INSERT, 32'h1234_5678, 6'd1);
        send_request(iltbl_pkg::CMD_SEARCH, iltbl_pkg::WORD_MIN, '0);
        send_request(iltbl_pkg::CMD_SEARCH, 32'd7, '0);
        send_request(iltbl_pkg::CMD_MAX, '0, '0);
        send_request(iltbl_pkg::CMD_MIN, '0, '0);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd4);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd0);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd5);
        send_request(iltbl_pkg::CMD_SEARCH, iltbl_pkg::WORD_MIN, '0);
    endtask

    // With writes denied, edits report denied and queries still work.
    task automatic test_write_protect();
        set_write_enable(1'b0);
        send_request(iltbl_pkg::CMD_APPEND, 32'd9, '0);
        send_request(iltbl_pkg::CMD_INSERT, 32'd9, 6'd0);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd0);
        send_request(iltbl_pkg::CMD_SEARCH, iltbl_pkg::WORD_MIN, '0);
        send_request(iltbl_pkg::CMD_MAX, '0, '0);
        set_write_enable(1'b1);
    endtask

    // Fill the store, check the full list against both permissions, edit the top end.
    task automatic test_full_list();
        while (list_len < LIST_DEPTH)
        begin
            send_request(iltbl_pkg::CMD_APPEND, $urandom,
                         iltbl_pkg::INDEX_W'($urandom_range(0, LIST_DEPTH - 1)));
            idle_cycles(pick_gap());
        end
        send_request(iltbl_pkg::CMD_APPEND, 32'd1, '0);
        send_request(iltbl_pkg::CMD_INSERT, 32'd1, 6'd0);
        send_request(iltbl_pkg::CMD_INSERT, 32'd1, 6'd63);
        // full must win over denied
        set_write_enable(1'b0);
        send_request(iltbl_pkg::CMD_APPEND, 32'd1, '0);
        send_request(iltbl_pkg::CMD_INSERT, 32'd1, 6'd63);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd0);
        set_write_enable(1'b1);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd63);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd63);
        send_request(iltbl_pkg::CMD_INSERT, iltbl_pkg::WORD_MAX, 6'd63);
        send_request(iltbl_pkg::CMD_MAX, '0, '0);
        send_request(iltbl_pkg::CMD_MIN, '0, '0);
        send_request(iltbl_pkg::CMD_SEARCH, iltbl_pkg::WORD_MAX, '0);
        send_request(iltbl_pkg::CMD_DELETE, '0, 6'd0);
        send_request(iltbl_pkg::CMD_INSERT, iltbl_pkg::WORD_MIN, 6'd0);
    endtask

    // Alternate growing and shrinking phases with random pacing; one phase denies writes.
    task automatic test_random_traffic();
        int  phase_len;
        bit  pace;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_write_enable(phase != 2);
            phase_len = (phase == 2) ? 120 : 300;
            pace      = (phase != 1 && phase != 4);
            for (int n = 0; n < phase_len; n++)
            begin
                send_random_request(phase % 2 == 0);
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                else if (pace)
                    idle_cycles(pick_gap());
            end
        end
    endtask

    // Check every result against the oldest queued reply.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            status_seen[status]++;
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d count %0d value %0d",
                         $time, "actual status", status, count, result_value);
                error_total++;
            end
            else
            begin
                want = reply_q.pop_front();
                checked_total++;
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    error_total++;
                end
                if (count !== want.count)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want.count, count);
                    error_total++;
                end
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value mismatch, expected %0d, actual %0d",
                             $time, want.value, result_value);
                    error_total++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no request taken and no result shown.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d replies outstanding",
                     $time, WATCH_LIMIT, reply_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edit_and_query();
        test_write_protect();
        test_full_list();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, reply_q.size());
            error_total++;
        end

        $display("covered %0d requests, %0d results checked, list depth up to %0d of %0d",
                 sent_total, checked_total, deepest_len, LIST_DEPTH);
        $display("statuses: ok %0d, full %0d, bad index %0d, denied %0d, not found %0d",
                 status_seen[iltbl_pkg::ST_OK], status_seen[iltbl_pkg::ST_FULL],
                 status_seen[iltbl_pkg::ST_BAD_INDEX], status_seen[iltbl_pkg::ST_DENIED],
                 status_seen[iltbl_pkg::ST_NOT_FOUND]);
        if (error_total == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> integer_list_table_engine_core.f
src/iltbl_pkg.sv
src/iltbl_ram.sv
src/integer_list_table_engine_core.sv
tb/tb.sv
